// File: design/sst_pkg.sv
// shared types and constants for the set span tracker
package sst_pkg;

    localparam int VALUE_W = 32;
    localparam int GAP_W   = 33;
    localparam int CAP_W   = 7;
    localparam int OUT_W   = 72;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;
    localparam logic [GAP_W-1:0] GAP_NONE       = {GAP_W{1'b1}};

    // register index taken from the word address
    localparam logic REG_CAPACITY = 1'b0;

    // one transaction traveling down the cell chain
    typedef struct packed {
        logic                      valid;
        logic                      cmp;      // stored value, compare against cells
        logic                      placed;   // already written into a cell
        logic signed [VALUE_W-1:0] value;
        logic        [GAP_W-1:0]   gap;      // smallest nonzero distance seen so far
        logic                      accepted;
        logic                      enough;
        logic        [VALUE_W-1:0] longest;
    } token_t;

endpackage

// File: design/sst_cell.sv
// one storage cell of the chain: holds a number and updates the passing token
module sst_cell
    import sst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  token_t tok_in,
    output token_t tok_out
);

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] num_reg;
    token_t                    tok_reg;
    token_t                    tok_next;
    logic                      store;
    logic        [VALUE_W-1:0] delta;

    always_comb
    begin
        delta = (tok_in.value >= num_reg) ? VALUE_W'(tok_in.value - num_reg)
                                          : VALUE_W'(num_reg - tok_in.value);
        store    = tok_in.valid && tok_in.cmp && !tok_in.placed && !valid_reg;
        tok_next = tok_in;
        if (tok_in.valid && tok_in.cmp && valid_reg && (delta != '0)
            && ({1'b0, delta} < tok_in.gap))
        begin
            tok_next.gap = {1'b0, delta};
        end
        if (store)
        begin
            tok_next.placed = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
            if (store)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && store)
        begin
            num_reg <= tok_in.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/set_span_tracker.sv
// top level: set span tracker with a chain of storage cells
//
// Input stream s_axis carries one signed 32-bit number per transaction. Each
// number is stored if the set holds fewer than min(capacity, MAX_NUMBERS)
// numbers, otherwise dropped. For every input transaction one result
// transaction leaves on m_axis: accepted, enough, longest span (max - min)
// and shortest span (smallest nonzero distance between stored numbers, else
// the longest span; both 0 with fewer than two numbers).
// Each transaction walks the chain of MAX_NUMBERS cells, one cell per cycle
// while the chain moves; a number that is stored compares against every
// stored number and writes itself into the first empty cell. A new
// transaction can enter every cycle, so throughput is one per cycle, as long
// as the receiver does not stall. When the receiver stalls with a result
// pending, the whole chain holds and s_axis_tready falls in the same cycle.
// Reset empties the set and sets capacity to 64. The APB port writes and
// reads capacity at address 0; write it only while the block is idle.
module set_span_tracker
    import sst_pkg::*;
#(
    parameter int MAX_NUMBERS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // [31:0] value
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,  // [0] accepted, [1] enough,
                                             // [33:2] longest_span,
                                             // [65:34] shortest_span, rest zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_NUMBERS + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]          capacity_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [VALUE_W-1:0] min_reg;
    logic signed [VALUE_W-1:0] max_reg;
    logic signed [VALUE_W-1:0] min_next;
    logic signed [VALUE_W-1:0] max_next;
    logic [GAP_W-1:0]          gap_reg;
    logic [GAP_W-1:0]          gap_next;
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic                      adv;
    logic                      in_fire;
    logic                      take;
    logic [LIM_W-1:0]          limit;
    logic                      enough_next;
    logic [VALUE_W-1:0]        shortest;
    logic signed [VALUE_W-1:0] in_value;
    token_t                    head_tok;
    token_t                    exit_tok;
    token_t                    chain [MAX_NUMBERS+1];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // the chain moves whenever the output register can take its exit
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;
    assign in_value      = $signed(s_axis_tdata);

    always_comb
    begin
        limit = (LIM_W'(capacity_reg) > LIM_W'(MAX_NUMBERS)) ? LIM_W'(MAX_NUMBERS)
                                                           : LIM_W'(capacity_reg);
        take       = LIM_W'(count_reg) < limit;
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (take)
        begin
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0)
            begin
                min_next = in_value;
                max_next = in_value;
            end
            else
            begin
                if (in_value < min_reg)
                begin
                    min_next = in_value;
                end
                if (in_value > max_reg)
                begin
                    max_next = in_value;
                end
            end
        end
        enough_next = count_next >= CNT_W'(2);

        head_tok.valid    = in_fire;
        head_tok.cmp      = take;
        head_tok.placed   = !take;
        head_tok.value    = in_value;
        head_tok.gap      = GAP_NONE;
        head_tok.accepted = take;
        head_tok.enough   = enough_next;
        head_tok.longest  = enough_next ? VALUE_W'(max_next - min_next) : '0;
    end

    assign chain[0] = head_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else if (in_fire)
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NUMBERS; gi++)
        begin : g_cell
            sst_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign exit_tok = chain[MAX_NUMBERS];

    // results leave in order, so the running gap folds in each token's gap
    always_comb
    begin
        gap_next = (exit_tok.gap < gap_reg) ? exit_tok.gap : gap_reg;
        if (!exit_tok.enough)
        begin
            shortest = '0;
        end
        else if (gap_next == GAP_NONE)
        begin
            shortest = exit_tok.longest;
        end
        else
        begin
            shortest = gap_next[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= GAP_NONE;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= exit_tok.valid;
            if (exit_tok.valid)
            begin
                gap_reg <= gap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && exit_tok.valid)
        begin
            out_data_reg <= {6'd0, shortest, exit_tok.longest,
                             exit_tok.enough, exit_tok.accepted};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a stored value must have found an empty cell by the end of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && exit_tok.valid && exit_tok.accepted) |-> exit_tok.placed)
        else $error("stored value left the chain without a cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NUMBERS))
        else $error("count beyond chain length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[65:34] <= m_axis_tdata[33:2]))
        else $error("shortest span above longest span");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[1])
            |-> (m_axis_tdata[65:34] == '0 && m_axis_tdata[33:2] == '0))
        else $error("spans nonzero without two numbers");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above maximum");

endmodule

// File: dv/set_span_tracker_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the set span tracker: stream stimulus, span prediction, apb setup
module set_span_tracker_tb;
    import sst_pkg::*;

    localparam int SET_DEPTH   = 64;
    localparam int LATENCY     = SET_DEPTH + 1;
    localparam int MAX_SHOWN   = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 70;
    localparam int NUM_PHASES  = 10;
    localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

    // packed so that accepted lands in bit 0, as on m_axis_tdata
    typedef struct packed {
        logic [VALUE_W-1:0] shortest;
        logic [VALUE_W-1:0] longest;
        logic               enough;
        logic               accepted;
    } span_report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // [31:0] value
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // [0] accepted, [1] enough, [33:2] longest_span,
                                            // [65:34] shortest_span
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // mirror of the block's set and capacity
    logic signed [VALUE_W-1:0] set_vals [SET_DEPTH];
    int                        set_count = 0;
    logic signed [VALUE_W-1:0] set_lo = '0;
    logic signed [VALUE_W-1:0] set_hi = '0;
    logic [GAP_W-1:0]          min_gap = GAP_NONE;
    logic [CAP_W-1:0]          cap_shadow = CAPACITY_RESET;

    logic [31:0]   pend_q [$];
    span_report_t  span_q [$];
    int            errors = 0;
    bit            item_taken = 1'b0;
    bit            hold_arm = 1'b0;
    int            hold_left = 0;
    int            send_idle_pct = 35;
    int            recv_idle_pct = 67;
    logic [31:0]   cluster_base = '0;
    int            phase_caps [NUM_PHASES] = '{6, 10, 16, 24, 36, 50, 60, 64, 127, 20};

    set_span_tracker #(.MAX_NUMBERS(SET_DEPTH)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void flag_error(input string what, input logic [VALUE_W-1:0] want,
                                       input logic [VALUE_W-1:0] got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // add one number to the mirrored set and report the spans it leaves
    function automatic span_report_t track_value(input logic signed [VALUE_W-1:0] v);
        int                 limit;
        int                 i;
        logic [VALUE_W:0]   diff;
        logic [VALUE_W-1:0] delta;
        span_report_t       r;
        r = '0;
        limit = (cap_shadow > SET_DEPTH) ? SET_DEPTH : int'(cap_shadow);
        if (set_count < limit)
        begin
            for (i = 0; i < set_count; i++)
            begin
                diff = {v[VALUE_W-1], v} - {set_vals[i][VALUE_W-1], set_vals[i]};
                delta = diff[VALUE_W] ? -diff[VALUE_W-1:0] : diff[VALUE_W-1:0];
                // equal numbers never count as a gap
                if (delta != '0 && {1'b0, delta} < min_gap)
                    min_gap = {1'b0, delta};
            end
            if (set_count == 0)
            begin
                set_lo = v;
                set_hi = v;
            end
            else
            begin
                if (v < set_lo)
                    set_lo = v;
                if (v > set_hi)
                    set_hi = v;
            end
            set_vals[set_count] = v;
            set_count++;
            r.accepted = 1'b1;
        end
        if (set_count >= 2)
        begin
            r.enough   = 1'b1;
            r.longest  = set_hi - set_lo;
            r.shortest = (min_gap == GAP_NONE) ? r.longest : min_gap[VALUE_W-1:0];
        end
        return r;
    endfunction

    function automatic void check_report(input span_report_t got);
        span_report_t want;
        if (span_q.size() == 0)
        begin
            flag_error("result with no pending transaction", '0, got.longest);
        end
        else
        begin
            want = span_q.pop_front();
            if (got.accepted != want.accepted)
                flag_error("accepted", VALUE_W'(want.accepted), VALUE_W'(got.accepted));
            if (got.enough != want.enough)
                flag_error("enough", VALUE_W'(want.enough), VALUE_W'(got.enough));
            if (got.longest != want.longest)
                flag_error("longest_span", want.longest, got.longest);
            if (got.shortest != want.shortest)
                flag_error("shortest_span", want.shortest, got.shortest);
        end
    endfunction

    // monitor: both streams sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                span_q.insert(span_q.size(), track_value(s_axis_tdata));
                item_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_report(span_report_t'(m_axis_tdata[2*VALUE_W+1:0]));
        end
    end

    // driver: valid holds until the transaction is taken
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !item_taken))
        begin
            if (item_taken)
            begin
                pend_q.delete(0);
                item_taken = 1'b0;
            end
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pend_q[0];
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_arm)
        begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // append one number to the stimulus queue
    task automatic queue_item(input logic [31:0] item);
        pend_q.insert(pend_q.size(), item);
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || span_q.size() != 0)
            @(negedge clk);
    endtask

    // write capacity, then read it back
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= {{(32-CAP_W){1'b0}}, cap};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cap_shadow = cap;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != {{(32-CAP_W){1'b0}}, cap})
            flag_error("capacity readback", {{(32-CAP_W){1'b0}}, cap}, rd);
    endtask

    initial
    begin
        int ph;
        logic [31:0] v;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // capacity zero: every value dropped, extremes of the field
        set_capacity(7'd0);
        queue_item(32'h8000_0000);
        queue_item(32'h7FFF_FFFF);
        queue_item(32'h0000_0000);
        queue_item(32'hFFFF_FFFF);
        drain();

        // a single number is not enough for a span
        set_capacity(7'd1);
        queue_item(32'd5);
        queue_item(32'd7);
        drain();

        // duplicates give no gap, then a full set drops
        set_capacity(7'd3);
        queue_item(32'd5);
        queue_item(32'd5);
        queue_item(32'hFFFF_FFF9);
        queue_item(32'd9);
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 67;
            end
            else if (ph < 7)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_capacity(phase_caps[ph][CAP_W-1:0]);
            cluster_base = $urandom;
            if (phase_caps[ph] == SET_DEPTH)
            begin
                // widest possible span while room is left
                queue_item(32'h8000_0000);
                queue_item(32'h7FFF_FFFF);
            end
            repeat (PHASE_ITEMS)
            begin
                case ($urandom_range(4))
                    0: v = $urandom;
                    1: v = cluster_base + $urandom_range(40) - 32'd20;
                    2: v = (set_count > 0) ? set_vals[$urandom_range(set_count - 1)] : $urandom;
                    3: v = $urandom_range(200) - 32'd100;
                    default: v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15)
                                                   : 32'h8000_0000 + $urandom_range(15);
                endcase
                queue_item(v);
            end
            // stall the output long enough for the chain to back up into the input
            if (ph == 7)
                hold_arm = 1'b1;
            drain();
        end

        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
design/sst_pkg.sv
design/sst_cell.sv
design/set_span_tracker.sv
dv/set_span_tracker_tb.sv
